// File: hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants, action codes and helpers for the correlation power
// analysis sum accumulator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    // Array extents in use; the index fields below bound them
    localparam int BYTE_POSITIONS = 16;
    localparam int KEY_GUESSES    = 256;
    localparam int SAMPLES        = 64;

    // Field widths
    localparam int ACT_W    = 3;
    localparam int BP_W     = 4;
    localparam int G_W      = 8;
    localparam int SI_W     = 6;
    localparam int VAL_W    = 16;
    localparam int FIRST_W  = 37;
    localparam int SECOND_W = 43;

    // Storage widths
    localparam int HYP_W    = 4;
    localparam int SX_W     = 28;
    localparam int SXX_W    = 43;
    localparam int SY_W     = 16;
    localparam int SYY_W    = 19;
    localparam int SXY_W    = 37;
    localparam int VSQ_W    = 31;
    localparam int PROD_W   = 21;

    localparam int PAIR_W   = BP_W + G_W;
    localparam int CROSS_AW = PAIR_W + SI_W;

    localparam int PAIR_DEPTH  = 2 ** PAIR_W;
    localparam int SAMP_DEPTH  = 2 ** SI_W;
    localparam int CROSS_DEPTH = 2 ** CROSS_AW;

    localparam logic [BP_W-1:0] BP_LAST = BP_W'(BYTE_POSITIONS - 1);
    localparam logic [G_W-1:0]  G_LAST  = G_W'(KEY_GUESSES - 1);
    localparam logic [SI_W-1:0] SI_LAST = SI_W'(SAMPLES - 1);

    // Actions
    localparam logic [ACT_W-1:0] ACT_LOAD_HYP = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_SAMP = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RD_SAMP  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_HYP   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RD_CROSS = 3'd4;

    localparam logic signed [VAL_W-1:0] HYP_MAX = 16'sd8;

    // Hypothesis distance clamped to 0..8
    function automatic logic [HYP_W-1:0] clamp_hyp(input logic signed [VAL_W-1:0] v);
        logic [HYP_W-1:0] h;
        if (v[VAL_W-1]) begin
            h = '0;
        end else if (v > HYP_MAX) begin
            h = HYP_W'(HYP_MAX);
        end else begin
            h = v[HYP_W-1:0];
        end
        return h;
    endfunction

endpackage

// File: hdl/cpa_ram.sv
// ----------------------------------------------------------------------------
// cpa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cpa_correlation_sum_accumulator_core.sv
// ----------------------------------------------------------------------------
// cpa_correlation_sum_accumulator_core
// Running sums for correlation power analysis, one trace at a time.
// ----------------------------------------------------------------------------
// After reset the block clears its sum memories, one entry per cycle, through
// all 262144 entries of the cross-sum memory; it takes no item until then.
// Each item is handled on its own: loads and reads go through a read state and
// a done state from acceptance to result. An add-sample item walks every byte
// position and key guess, one read-modify-write of the cross-sum memory per
// cycle. The next item is taken as soon as the result is posted, even if that
// result is still stalled.
module cpa_correlation_sum_accumulator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cpa_pkg::ACT_W-1:0]            i_action,
    input  logic [cpa_pkg::BP_W-1:0]             i_byte_pos,
    input  logic [cpa_pkg::G_W-1:0]              i_guess,
    input  logic [cpa_pkg::SI_W-1:0]             i_sample_index,
    input  logic signed [cpa_pkg::VAL_W-1:0]     i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [cpa_pkg::FIRST_W-1:0]   o_first_sum,
    output logic [cpa_pkg::SECOND_W-1:0]         o_second_sum
);
    import cpa_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LOOP  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [CROSS_AW-1:0]     CLR_LAST = '1;
    localparam logic signed [SX_W-1:0]  SX_MIN   = {1'b1, {(SX_W-1){1'b0}}};
    localparam logic signed [SX_W-1:0]  SX_MAX   = {1'b0, {(SX_W-1){1'b1}}};
    localparam logic signed [SXY_W-1:0] SXY_MIN  = {1'b1, {(SXY_W-1){1'b0}}};
    localparam logic signed [SXY_W-1:0] SXY_MAX  = {1'b0, {(SXY_W-1){1'b1}}};

    logic [2:0]          r_state, n_state;
    logic [CROSS_AW-1:0] r_clr;
    logic                w_in_acc;

    // captured item
    logic [ACT_W-1:0]        r_act;
    logic [BP_W-1:0]         r_bp;
    logic [G_W-1:0]          r_g;
    logic [SI_W-1:0]         r_si;
    logic signed [VAL_W-1:0] r_val;
    logic [HYP_W-1:0]        r_h;
    logic [VSQ_W-1:0]        r_sq;
    logic                    r_pair_ok;
    logic                    r_samp_ok;
    logic signed [31:0]      w_vsq;

    // cross-sum walk: issue, data, write-back
    logic              r_rd_run;
    logic [BP_W-1:0]   r_rd_bp;
    logic [G_W-1:0]    r_rd_g;
    logic              w_rd_last;
    logic              r_b_valid;
    logic              r_b_last;
    logic [BP_W-1:0]   r_b_bp;
    logic [G_W-1:0]    r_b_g;
    logic              r_c_valid;
    logic              r_c_last;
    logic [BP_W-1:0]   r_c_bp;
    logic [G_W-1:0]    r_c_g;
    logic signed [PROD_W-1:0] r_c_prod;
    logic signed [SXY_W-1:0]  r_c_sum;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SXY_W:0]    w_cx;
    logic signed [SXY_W-1:0]  w_cx_sat;

    // result
    logic signed [FIRST_W-1:0] r_res_first;
    logic [SECOND_W-1:0]       r_res_second;
    logic                      r_out_valid;
    logic signed [FIRST_W-1:0] r_out_first;
    logic [SECOND_W-1:0]       r_out_second;
    logic                      w_post;

    // memory ports
    logic                       w_samp_we;
    logic [SI_W-1:0]            w_samp_waddr;
    logic [SX_W+SXX_W-1:0]      w_samp_wdata;
    logic [SX_W+SXX_W-1:0]      w_samp_q;
    logic                       w_hs_we;
    logic [PAIR_W-1:0]          w_hs_waddr;
    logic [SY_W+SYY_W-1:0]      w_hs_wdata;
    logic [SY_W+SYY_W-1:0]      w_hs_q;
    logic                       w_hyp_we;
    logic [HYP_W-1:0]           w_hyp_q;
    logic                       w_cx_we;
    logic [CROSS_AW-1:0]        w_cx_waddr;
    logic [CROSS_AW-1:0]        w_cx_raddr;
    logic [SXY_W-1:0]           w_cx_wdata;
    logic [SXY_W-1:0]           w_cx_q;

    // read-modify-write arithmetic
    logic signed [SX_W-1:0]  w_samp_sum;
    logic [SXX_W-1:0]        w_samp_sq;
    logic signed [SX_W:0]    w_sx;
    logic signed [SX_W-1:0]  w_sx_sat;
    logic [SXX_W:0]          w_sxx;
    logic [SXX_W-1:0]        w_sxx_sat;
    logic [SY_W-1:0]         w_hsum;
    logic [SYY_W-1:0]        w_hsq;
    logic [7:0]              w_hh;
    logic [SY_W:0]           w_sy;
    logic [SYY_W:0]          w_syy;
    logic [SY_W-1:0]         w_sy_sat;
    logic [SYY_W-1:0]        w_syy_sat;

    assign w_in_acc = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign w_vsq    = i_value * i_value;
    assign w_post   = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign w_rd_last = (r_rd_bp == BP_LAST) && (r_rd_g == G_LAST);

    // ---------------- sample sums ----------------
    assign w_samp_sum = w_samp_q[SX_W+SXX_W-1:SXX_W];
    assign w_samp_sq  = w_samp_q[SXX_W-1:0];
    assign w_sx       = (SX_W+1)'(w_samp_sum) + (SX_W+1)'(r_val);
    assign w_sx_sat   = (w_sx[SX_W] != w_sx[SX_W-1]) ? (w_sx[SX_W] ? SX_MIN : SX_MAX)
                                                     : w_sx[SX_W-1:0];
    assign w_sxx      = {1'b0, w_samp_sq} + (SXX_W+1)'(r_sq);
    assign w_sxx_sat  = w_sxx[SXX_W] ? '1 : w_sxx[SXX_W-1:0];

    assign w_samp_we    = (r_state == ST_CLEAR) ||
                          ((r_state == ST_READ) && (r_act == ACT_ADD_SAMP) && r_samp_ok);
    assign w_samp_waddr = (r_state == ST_CLEAR) ? r_clr[SI_W-1:0] : r_si;
    assign w_samp_wdata = (r_state == ST_CLEAR) ? '0 : {w_sx_sat, w_sxx_sat};

    cpa_ram #(.WIDTH(SX_W + SXX_W), .DEPTH(SAMP_DEPTH)) u_samp_ram (
        .i_clk   (i_clk),
        .i_we    (w_samp_we),
        .i_waddr (w_samp_waddr),
        .i_wdata (w_samp_wdata),
        .i_raddr (i_sample_index),
        .o_rdata (w_samp_q)
    );

    // ---------------- hypothesis sums ----------------
    assign w_hsum    = w_hs_q[SY_W+SYY_W-1:SYY_W];
    assign w_hsq     = w_hs_q[SYY_W-1:0];
    assign w_hh      = r_h * r_h;
    assign w_sy      = {1'b0, w_hsum} + (SY_W+1)'(r_h);
    assign w_syy     = {1'b0, w_hsq} + (SYY_W+1)'(w_hh);
    assign w_sy_sat  = w_sy[SY_W] ? '1 : w_sy[SY_W-1:0];
    assign w_syy_sat = w_syy[SYY_W] ? '1 : w_syy[SYY_W-1:0];

    assign w_hyp_we   = (r_state == ST_READ) && (r_act == ACT_LOAD_HYP) && r_pair_ok;
    assign w_hs_we    = (r_state == ST_CLEAR) || w_hyp_we;
    assign w_hs_waddr = (r_state == ST_CLEAR) ? r_clr[PAIR_W-1:0] : {r_bp, r_g};
    assign w_hs_wdata = (r_state == ST_CLEAR) ? '0 : {w_sy_sat, w_syy_sat};

    cpa_ram #(.WIDTH(SY_W + SYY_W), .DEPTH(PAIR_DEPTH)) u_hsum_ram (
        .i_clk   (i_clk),
        .i_we    (w_hs_we),
        .i_waddr (w_hs_waddr),
        .i_wdata (w_hs_wdata),
        .i_raddr ({i_byte_pos, i_guess}),
        .o_rdata (w_hs_q)
    );

    // stored hypotheses, read along the cross-sum walk
    cpa_ram #(.WIDTH(HYP_W), .DEPTH(PAIR_DEPTH)) u_hyp_ram (
        .i_clk   (i_clk),
        .i_we    (w_hyp_we),
        .i_waddr ({r_bp, r_g}),
        .i_wdata (r_h),
        .i_raddr ({r_rd_bp, r_rd_g}),
        .o_rdata (w_hyp_q)
    );

    // ---------------- cross sums ----------------
    // Walk reads entry p+2 while writing back entry p, so no two accesses meet.
    assign w_prod     = $signed({1'b0, w_hyp_q}) * r_val;
    assign w_cx       = (SXY_W+1)'(r_c_sum) + (SXY_W+1)'(r_c_prod);
    assign w_cx_sat   = (w_cx[SXY_W] != w_cx[SXY_W-1]) ? (w_cx[SXY_W] ? SXY_MIN : SXY_MAX)
                                                       : w_cx[SXY_W-1:0];
    assign w_cx_raddr = (r_state == ST_IDLE) ? {i_byte_pos, i_guess, i_sample_index}
                                             : {r_rd_bp, r_rd_g, r_si};
    assign w_cx_we    = (r_state == ST_CLEAR) || r_c_valid;
    assign w_cx_waddr = (r_state == ST_CLEAR) ? r_clr : {r_c_bp, r_c_g, r_si};
    assign w_cx_wdata = (r_state == ST_CLEAR) ? '0 : w_cx_sat;

    cpa_ram #(.WIDTH(SXY_W), .DEPTH(CROSS_DEPTH)) u_cross_ram (
        .i_clk   (i_clk),
        .i_we    (w_cx_we),
        .i_waddr (w_cx_waddr),
        .i_wdata (w_cx_wdata),
        .i_raddr (w_cx_raddr),
        .o_rdata (w_cx_q)
    );

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if ((r_act == ACT_ADD_SAMP) && r_samp_ok) begin
                    n_state = ST_LOOP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LOOP: begin
                if (r_c_valid && r_c_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_post) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rd_run    <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == ST_READ) && (r_act == ACT_ADD_SAMP) && r_samp_ok) begin
                r_rd_run <= 1'b1;
            end else if (r_rd_run && w_rd_last) begin
                r_rd_run <= 1'b0;
            end
            r_b_valid <= r_rd_run;
            r_c_valid <= r_b_valid;
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act     <= i_action;
            r_bp      <= i_byte_pos;
            r_g       <= i_guess;
            r_si      <= i_sample_index;
            r_val     <= i_value;
            r_h       <= clamp_hyp(i_value);
            r_sq      <= w_vsq[VSQ_W-1:0];
            r_pair_ok <= (i_byte_pos <= BP_LAST) && (i_guess <= G_LAST);
            r_samp_ok <= (i_sample_index <= SI_LAST);
        end

        // walk counters
        if (r_state == ST_READ) begin
            r_rd_bp <= '0;
            r_rd_g  <= '0;
        end else if (r_rd_run) begin
            if (r_rd_g == G_LAST) begin
                r_rd_g  <= '0;
                r_rd_bp <= r_rd_bp + 1'b1;
            end else begin
                r_rd_g <= r_rd_g + 1'b1;
            end
        end
        r_b_bp   <= r_rd_bp;
        r_b_g    <= r_rd_g;
        r_b_last <= w_rd_last;
        r_c_bp   <= r_b_bp;
        r_c_g    <= r_b_g;
        r_c_last <= r_b_last;
        r_c_prod <= w_prod;
        r_c_sum  <= $signed(w_cx_q);

        if (r_state == ST_READ) begin
            r_res_first  <= '0;
            r_res_second <= '0;
            case (r_act)
                ACT_RD_SAMP: begin
                    if (r_samp_ok) begin
                        r_res_first  <= FIRST_W'(w_samp_sum);
                        r_res_second <= w_samp_sq;
                    end
                end
                ACT_RD_HYP: begin
                    if (r_pair_ok) begin
                        r_res_first  <= FIRST_W'(w_hsum);
                        r_res_second <= SECOND_W'(w_hsq);
                    end
                end
                ACT_RD_CROSS: begin
                    if (r_pair_ok && r_samp_ok) begin
                        r_res_first <= $signed(w_cx_q);
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_post) begin
            r_out_first  <= r_res_first;
            r_out_second <= r_res_second;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_first_sum  = r_out_first;
    assign o_second_sum = r_out_second;

endmodule

// File: hdl/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks for the correlation sum accumulator, bound to the core.
// ----------------------------------------------------------------------------
module cpa_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic [cpa_pkg::ACT_W-1:0]            i_action,
    input  logic [cpa_pkg::BP_W-1:0]             i_byte_pos,
    input  logic [cpa_pkg::G_W-1:0]              i_guess,
    input  logic [cpa_pkg::SI_W-1:0]             i_sample_index,
    input  logic signed [cpa_pkg::VAL_W-1:0]     i_value,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [cpa_pkg::FIRST_W-1:0]   o_first_sum,
    input  logic [cpa_pkg::SECOND_W-1:0]         o_second_sum
);
    import cpa_pkg::*;

    logic             w_in_acc;
    logic             w_new;
    logic             w_no_data;
    logic             r_pend;
    logic [ACT_W-1:0] r_act;
    logic             r_prev_ov;
    logic             r_prev_oacc;
    logic             w_unused;

    assign w_in_acc  = i_valid && !o_stall;
    // a fresh result shows on the output this cycle
    assign w_new     = o_valid && (!r_prev_ov || r_prev_oacc);
    assign w_no_data = (r_act != ACT_RD_SAMP) && (r_act != ACT_RD_HYP) &&
                       (r_act != ACT_RD_CROSS);
    assign w_unused  = ^{i_byte_pos, i_guess, i_sample_index, i_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_prev_ov   <= 1'b0;
            r_prev_oacc <= 1'b0;
        end else begin
            r_prev_ov   <= o_valid;
            r_prev_oacc <= o_valid && !i_stall;
            if (w_in_acc) begin
                r_pend <= 1'b1;
            end else if (w_new) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act <= i_action;
        end
    end

    // one item in flight: stall follows every acceptance
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("item accepted while another is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_first_sum) && $stable(o_second_sum)))
        else $error("stalled result changed");

    a_no_second_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (!r_pend || w_new))
        else $error("new item accepted before previous result posted");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_new && w_no_data && !w_unused && 1'b1) || (w_new && w_no_data && w_unused)
        |-> ((o_first_sum == '0) && (o_second_sum == '0)))
        else $error("non-read action returned nonzero sums");

    a_cross_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_new && (r_act == ACT_RD_CROSS)) |-> (o_second_sum == '0))
        else $error("cross read returned nonzero second sum");

endmodule

bind cpa_correlation_sum_accumulator_core cpa_checker u_cpa_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the correlation power analysis sum accumulator.
// A queue of items (hypothesis loads, sample adds, reads, spare actions) is
// driven in random bursts; a local model of every sum predicts each result,
// and results are checked in order against it under random output stalls.
// ----------------------------------------------------------------------------
module tb;
    import cpa_pkg::*;

    localparam int IDLE_LIMIT  = 1_100_000;  // outlasts the clear pass after reset
    localparam int RAND_ITEMS  = 110;
    localparam int HOLD_CYCLES = 10_000;     // outlasts two sample adds
    localparam int HOLD_AFTER  = 40;
    localparam int TAIL_CYCLES = 20;
    localparam int WS_PAIRS    = 8;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam longint SX_HI  = (longint'(1) << (SX_W - 1)) - 1;
    localparam longint SX_LO  = -(longint'(1) << (SX_W - 1));
    localparam longint SXX_HI = (longint'(1) << SXX_W) - 1;
    localparam longint SY_HI  = (longint'(1) << SY_W) - 1;
    localparam longint SYY_HI = (longint'(1) << SYY_W) - 1;
    localparam longint SXY_HI = (longint'(1) << (SXY_W - 1)) - 1;
    localparam longint SXY_LO = -(longint'(1) << (SXY_W - 1));

    localparam logic signed [VAL_W-1:0] CORNER_HYP [WS_PAIRS] =
        '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd8, 16'sd9, 16'sd0, 16'sd7, 16'sd1};

    typedef struct {
        logic [ACT_W-1:0]        action;
        logic [BP_W-1:0]         byte_pos;
        logic [G_W-1:0]          guess;
        logic [SI_W-1:0]         sample_index;
        logic signed [VAL_W-1:0] value;
        bit                      drain;
    } t_cpa_item;

    typedef struct {
        logic signed [FIRST_W-1:0] first;
        logic [SECOND_W-1:0]       second;
    } t_sums;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_valid        = 1'b0;
    logic                        o_stall;
    logic [ACT_W-1:0]            i_action       = ACT_LOAD_HYP;
    logic [BP_W-1:0]             i_byte_pos     = '0;
    logic [G_W-1:0]              i_guess        = '0;
    logic [SI_W-1:0]             i_sample_index = '0;
    logic signed [VAL_W-1:0]     i_value        = '0;
    logic                        o_valid;
    logic                        i_stall        = 1'b0;
    logic signed [FIRST_W-1:0]   o_first_sum;
    logic [SECOND_W-1:0]         o_second_sum;

    // predicted accumulator state
    bit [HYP_W-1:0] hyp_store   [PAIR_DEPTH];
    longint         hyp_sum     [PAIR_DEPTH];
    longint         hyp_sq_sum  [PAIR_DEPTH];
    longint         samp_sum    [SAMPLES];
    longint         samp_sq_sum [SAMPLES];
    longint         cross_sum   [CROSS_DEPTH];

    // stimulus-side bookkeeping: which cross terms are defined
    bit              hyp_loaded  [PAIR_DEPTH];
    bit              cross_undef [CROSS_DEPTH];
    logic [SI_W-1:0] added_si [$];
    logic [BP_W-1:0] ws_bp [WS_PAIRS];
    logic [G_W-1:0]  ws_g  [WS_PAIRS];
    bit              drain_next;

    t_cpa_item   stim_q [$];
    t_sums       sums_due [$];
    t_cpa_item   held;
    int          errors       = 0;
    int          results_seen = 0;
    int          gap_left     = 0;
    int          burst_left   = 1;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned rx_tick      = 0;
    int          idle_cycles  = 0;

    cpa_correlation_sum_accumulator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_byte_pos     (i_byte_pos),
        .i_guess        (i_guess),
        .i_sample_index (i_sample_index),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_first_sum    (o_first_sum),
        .o_second_sum   (o_second_sum)
    );

    initial forever #2 i_clk = ~i_clk;

    function automatic longint sat_add(longint acc, longint inc, longint lo, longint hi);
        longint r;
        r = acc + inc;
        if (r < lo) begin
            r = lo;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    task automatic update_sums(input t_cpa_item it, output t_sums res);
        int     pair;
        int     si;
        longint v;
        longint h;
        pair = int'({it.byte_pos, it.guess});
        si   = int'(it.sample_index);
        v    = longint'(it.value);
        res.first  = '0;
        res.second = '0;
        case (it.action)
            ACT_LOAD_HYP: begin
                h = (v < 0) ? 0 : ((v > longint'(HYP_MAX)) ? longint'(HYP_MAX) : v);
                hyp_store[pair]  = HYP_W'(h);
                hyp_sum[pair]    = sat_add(hyp_sum[pair], h, 0, SY_HI);
                hyp_sq_sum[pair] = sat_add(hyp_sq_sum[pair], h * h, 0, SYY_HI);
            end
            ACT_ADD_SAMP: begin
                samp_sum[si]    = sat_add(samp_sum[si], v, SX_LO, SX_HI);
                samp_sq_sum[si] = sat_add(samp_sq_sum[si], v * v, 0, SXX_HI);
                for (int p = 0; p < PAIR_DEPTH; p++) begin
                    cross_sum[p * SAMPLES + si] = sat_add(cross_sum[p * SAMPLES + si],
                        longint'(hyp_store[p]) * v, SXY_LO, SXY_HI);
                end
            end
            ACT_RD_SAMP: begin
                res.first  = FIRST_W'(samp_sum[si]);
                res.second = SECOND_W'(samp_sq_sum[si]);
            end
            ACT_RD_HYP: begin
                res.first  = FIRST_W'(hyp_sum[pair]);
                res.second = SECOND_W'(hyp_sq_sum[pair]);
            end
            ACT_RD_CROSS: begin
                res.first = FIRST_W'(cross_sum[pair * SAMPLES + si]);
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [ACT_W-1:0] act, input logic [BP_W-1:0] bp,
                              input logic [G_W-1:0] g, input logic [SI_W-1:0] si,
                              input logic signed [VAL_W-1:0] v);
        t_cpa_item it;
        it.action       = act;
        it.byte_pos     = bp;
        it.guess        = g;
        it.sample_index = si;
        it.value        = v;
        it.drain        = drain_next;
        drain_next      = 1'b0;
        if (act == ACT_LOAD_HYP) begin
            hyp_loaded[int'({bp, g})] = 1'b1;
        end
        if (act == ACT_ADD_SAMP) begin
            // a pair never loaded gets an undefined cross term at this index
            for (int p = 0; p < PAIR_DEPTH; p++) begin
                if (!hyp_loaded[p]) begin
                    cross_undef[p * SAMPLES + int'(si)] = 1'b1;
                end
            end
            added_si.push_back(si);
        end
        stim_q.push_back(it);
    endtask

    function automatic logic signed [VAL_W-1:0] sample_val();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(VAL_W - 1){1'b0}}};
            1:       return {1'b0, {(VAL_W - 1){1'b1}}};
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] hyp_val();
        return ($urandom_range(0, 9) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 8));
    endfunction

    function automatic logic [ACT_W-1:0] spare_action();
        return ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    endfunction

    function automatic logic [SI_W-1:0] pick_added_si();
        return added_si[$urandom_range(0, added_si.size() - 1)];
    endfunction

    initial begin : stimulus
        logic [BP_W-1:0] bp;
        logic [G_W-1:0]  g;
        logic [SI_W-1:0] si;
        int              k;
        int              n_rand;
        int              trace_no;

        // corners of the pair space, alternating bit patterns, two random pairs
        ws_bp[0] = '0;      ws_g[0] = '0;
        ws_bp[1] = BP_LAST; ws_g[1] = G_LAST;
        ws_bp[2] = '0;      ws_g[2] = G_LAST;
        ws_bp[3] = BP_LAST; ws_g[3] = '0;
        ws_bp[4] = 4'hA;    ws_g[4] = 8'h55;
        ws_bp[5] = 4'h5;    ws_g[5] = 8'hAA;
        for (k = 6; k < WS_PAIRS; k++) begin
            ws_bp[k] = BP_W'($urandom);
            ws_g[k]  = G_W'($urandom);
        end

        // directed: zero sums after reset
        queue_item(ACT_RD_SAMP, BP_W'($urandom), G_W'($urandom), '0, sample_val());
        queue_item(ACT_RD_SAMP, BP_W'($urandom), G_W'($urandom), SI_LAST, sample_val());
        queue_item(ACT_RD_HYP, BP_LAST, G_LAST, SI_W'($urandom), sample_val());
        // hypothesis loads, out-of-range values clamp
        for (k = 0; k < WS_PAIRS; k++) begin
            queue_item(ACT_LOAD_HYP, ws_bp[k], ws_g[k], SI_W'($urandom), CORNER_HYP[k]);
        end
        // extreme samples at the end indexes and -1 at index 5, then read-backs and spare actions
        queue_item(ACT_ADD_SAMP, BP_W'($urandom), G_W'($urandom), '0, 16'sh7fff);
        queue_item(ACT_ADD_SAMP, BP_W'($urandom), G_W'($urandom), SI_LAST, 16'sh8000);
        queue_item(ACT_ADD_SAMP, BP_W'($urandom), G_W'($urandom), 6'd5, -16'sd1);
        queue_item(ACT_RD_CROSS, ws_bp[0], ws_g[0], '0, sample_val());
        queue_item(ACT_RD_CROSS, ws_bp[1], ws_g[1], SI_LAST, sample_val());
        queue_item(ACT_RD_CROSS, ws_bp[2], ws_g[2], 6'd5, sample_val());
        queue_item(ACT_RD_CROSS, ws_bp[3], ws_g[3], '0, sample_val());
        queue_item(ACT_RD_SAMP, BP_W'($urandom), G_W'($urandom), '0, sample_val());
        queue_item(ACT_RD_SAMP, BP_W'($urandom), G_W'($urandom), SI_LAST, sample_val());
        queue_item(ACT_RD_HYP, ws_bp[0], ws_g[0], SI_W'($urandom), sample_val());
        queue_item(ACT_RD_HYP, ws_bp[1], ws_g[1], SI_W'($urandom), sample_val());
        queue_item(ACT_SPARE_LO, BP_W'($urandom), G_W'($urandom), SI_W'($urandom), sample_val());
        queue_item(ACT_SPARE_HI, BP_W'($urandom), G_W'($urandom), SI_W'($urandom), sample_val());

        // random traces: reload hypotheses, add samples, then a mix of reads, extra loads and spare actions
        drain_next = 1'b1;
        n_rand     = 0;
        trace_no   = 0;
        while (n_rand < RAND_ITEMS) begin
            if (trace_no == 4) begin
                drain_next = 1'b1;
            end
            for (k = 0; k < WS_PAIRS; k++) begin
                queue_item(ACT_LOAD_HYP, ws_bp[k], ws_g[k], SI_W'($urandom), hyp_val());
            end
            n_rand += WS_PAIRS;
            repeat ($urandom_range(1, 4)) begin
                queue_item(ACT_ADD_SAMP, BP_W'($urandom), G_W'($urandom), SI_W'($urandom),
                           sample_val());
                n_rand++;
            end
            repeat ($urandom_range(3, 7)) begin
                k = $urandom_range(0, WS_PAIRS - 1);
                case ($urandom_range(0, 9)) inside
                    [0:1]: begin
                        si = $urandom_range(0, 1) ? pick_added_si() : SI_W'($urandom);
                        queue_item(ACT_RD_SAMP, BP_W'($urandom), G_W'($urandom), si, sample_val());
                        n_rand++;
                    end
                    [2:3]: begin
                        if ($urandom_range(0, 1)) begin
                            bp = ws_bp[k];
                            g  = ws_g[k];
                        end else begin
                            bp = BP_W'($urandom);
                            g  = G_W'($urandom);
                        end
                        queue_item(ACT_RD_HYP, bp, g, SI_W'($urandom), sample_val());
                        n_rand++;
                    end
                    7: begin
                        queue_item(ACT_LOAD_HYP, BP_W'($urandom), G_W'($urandom),
                                   SI_W'($urandom), hyp_val());
                        n_rand++;
                    end
                    8: begin
                        queue_item(spare_action(), BP_W'($urandom), G_W'($urandom),
                                   SI_W'($urandom), sample_val());
                    end
                    default: begin
                        if ($urandom_range(0, 3) != 0) begin
                            bp = ws_bp[k];
                            g  = ws_g[k];
                            si = pick_added_si();
                        end else begin
                            bp = BP_W'($urandom);
                            g  = G_W'($urandom);
                            si = SI_W'($urandom);
                            if (cross_undef[int'({bp, g, si})]) begin
                                bp = ws_bp[k];
                                g  = ws_g[k];
                            end
                        end
                        queue_item(ACT_RD_CROSS, bp, g, si, sample_val());
                        n_rand++;
                    end
                endcase
            end
            trace_no++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (stim_q.size() != 0 || i_valid || sums_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // sender: bursts of items with random gaps; a drain-marked item waits
    // until every outstanding result has been checked
    always @(posedge i_clk) begin : sender
        t_sums res;
        bit    offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && !o_stall) begin
                update_sums(held, res);
                sums_due.push_back(res);
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() != 0 && (!stim_q[0].drain || sums_due.size() == 0)) begin
                    held = stim_q.pop_front();
                    i_action       <= held.action;
                    i_byte_pos     <= held.byte_pos;
                    i_guess        <= held.guess;
                    i_sample_index <= held.sample_index;
                    i_value        <= held.value;
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            i_valid <= offer;
        end
    end

    // receiver: checks each result in order and stalls on its own pattern
    always @(posedge i_clk) begin : receiver
        t_sums want;
        bit    stall;
        if (o_valid && !i_stall) begin
            results_seen++;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got first %0d second %0d",
                         $time, o_first_sum, o_second_sum);
                errors++;
            end else begin
                want = sums_due.pop_front();
                if (o_first_sum !== want.first) begin
                    $display("%0t: first_sum mismatch, expected %0d, got %0d",
                             $time, want.first, o_first_sum);
                    errors++;
                end
                if (o_second_sum !== want.second) begin
                    $display("%0t: second_sum mismatch, expected %0d, got %0d",
                             $time, want.second, o_second_sum);
                    errors++;
                end
            end
        end
        rx_tick++;
        // one long hold so the block backs up and stalls its input
        if (results_seen == HOLD_AFTER && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            stall = 1'b1;
            hold_left--;
        end else begin
            case (rx_tick[10:9])
                2'd0:    stall = 1'b0;
                2'd1:    stall = ($urandom_range(0, 3) == 0);
                2'd2:    stall = ($urandom_range(0, 3) != 0);
                default: stall = (rx_tick[2:0] < 3'd3);
            endcase
        end
        i_stall <= stall;
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
